FILE: sv/jtsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_pkg
// Shared types and constants of the calibrated joystick-to-servo mapper.
// ----------------------------------------------------------------------------
package jtsm_pkg;

   localparam int NUM_AXES = 4;

   localparam logic [10:0] PULSE_MIN  = 11'd500;
   localparam logic [10:0] PULSE_MAX  = 11'd2000;
   localparam logic [10:0] BIAS_LIMIT = 11'd750;

   // floor(v * 1500 / 1023) == (v * SCALE_MULT) >> SCALE_SHIFT for every 10-bit v
   localparam logic [31:0] SCALE_MULT  = 32'd3148804500;
   localparam int          SCALE_SHIFT = 31;

   localparam logic [1:0] MODE_RIGHT = 2'h1;
   localparam logic [1:0] MODE_LEFT  = 2'h2;

   typedef logic [9:0]         axis_type;
   typedef logic [10:0]        scaled_type;
   typedef logic signed [11:0] bias_type;

   typedef struct packed {
      logic [9:0] right_x;
      logic [9:0] right_y;
      logic [9:0] left_x;
      logic [9:0] left_y;
      logic       right_cal_switch;
      logic       left_cal_switch;
      logic       save_button;
   } req_payload_type;

   typedef struct packed {
      logic [10:0] right_x_pulse;
      logic [10:0] right_y_pulse;
      logic [10:0] left_x_pulse;
      logic [10:0] left_y_pulse;
      logic        right_drive;
      logic        left_drive;
      logic        save_request;
   } rsp_payload_type;

   typedef struct packed {
      logic right_cal_switch;
      logic left_cal_switch;
      logic save_button;
   } ctl_type;

   typedef struct packed {
      logic right_drive;
      logic left_drive;
      logic save_request;
   } flags_type;

endpackage

FILE: sv/joystick_to_servo_calibrated_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_to_servo_calibrated_mapper_top
// Maps one joystick packet to four calibrated servo pulses and status flags.
//
// Input channel req_*: one packet per transaction, four 10-bit axes, two
// calibration switches and an active-low save button.
// Result channel rsp_*: one result per packet, four pulse widths in us
// (500..2000), a drive flag per stick and a save request.
// Four scaling lanes run in parallel, then a calibration stage applies the
// switch edges and updates the stored biases, then four clamp lanes.
// A packet passes the scale, calibration and clamp registers in turn. One
// packet per cycle while the receiver takes results; each stage holds one.
// When the receiver stalls, stages fill behind the held result and
// req_ready drops only once every stage is occupied.
// Reset clears all valid bits, both calibration modes and all biases.
// ----------------------------------------------------------------------------
module joystick_to_servo_calibrated_mapper_top
   import jtsm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic en1;
   logic en2;
   logic en3;
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;

   axis_type   [NUM_AXES-1:0] samples;
   scaled_type [NUM_AXES-1:0] scaled1;
   scaled_type [NUM_AXES-1:0] scaled2;
   bias_type   [NUM_AXES-1:0] bias2;
   logic       [10:0]         pulse3 [NUM_AXES];
   ctl_type                   ctl_ff;
   ctl_type                   ctl_in;
   flags_type                 flags2;
   flags_type                 flags_ff;

   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v3_ff;

   assign samples = {req_payload.left_y, req_payload.left_x,
                     req_payload.right_y, req_payload.right_x};

   assign ctl_in = '{right_cal_switch: req_payload.right_cal_switch,
                     left_cal_switch:  req_payload.left_cal_switch,
                     save_button:      req_payload.save_button};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ctl_ff <= ctl_in;
      end
      if (en3) begin
         flags_ff <= flags2;
      end
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_scale
      jtsm_scale u_scale (
         .clock     (clock),
         .enable    (en1),
         .sample    (samples[i]),
         .scaled_ff (scaled1[i])
      );
   end

   jtsm_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .enable    (en2),
      .update    (v1_ff && en2),
      .scaled    (scaled1),
      .ctl       (ctl_ff),
      .scaled_ff (scaled2),
      .bias_ff   (bias2),
      .flags_ff  (flags2)
   );

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_clamp
      jtsm_clamp u_clamp (
         .clock    (clock),
         .enable   (en3),
         .scaled   (scaled2[i]),
         .bias     (bias2[i]),
         .pulse_ff (pulse3[i])
      );
   end

   always_comb begin
      rsp_payload.right_x_pulse = pulse3[0];
      rsp_payload.right_y_pulse = pulse3[1];
      rsp_payload.left_x_pulse  = pulse3[2];
      rsp_payload.left_y_pulse  = pulse3[3];
      rsp_payload.right_drive   = flags_ff.right_drive;
      rsp_payload.left_drive    = flags_ff.left_drive;
      rsp_payload.save_request  = flags_ff.save_request;
   end

   save_needs_idle_a : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.save_request |->
         rsp_payload.right_drive && rsp_payload.left_drive)
      else $error("save request while a stick calibrates");

   pulse_range_a : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_payload.right_x_pulse >= PULSE_MIN) && (rsp_payload.right_x_pulse <= PULSE_MAX)
         && (rsp_payload.left_y_pulse >= PULSE_MIN) && (rsp_payload.left_y_pulse <= PULSE_MAX))
      else $error("pulse outside servo range");

   no_stall_ready_a : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output stage");

   accept_latency_a : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 v2_ff)
      else $error("accepted transaction lost in pipeline");

endmodule

FILE: sv/jtsm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_scale
// One axis lane: maps a 10-bit sample onto 500..2000 us, registered.
// ----------------------------------------------------------------------------
module jtsm_scale
   import jtsm_pkg::*;
(
   input  logic       clock,
   input  logic       enable,
   input  axis_type   sample,
   output scaled_type scaled_ff
);

   logic [41:0] product;
   scaled_type  scaled_in;

   always_comb begin
      product   = 42'(sample) * 42'(SCALE_MULT);
      scaled_in = product[41:SCALE_SHIFT] + PULSE_MIN;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         scaled_ff <= scaled_in;
      end
   end

endmodule

FILE: sv/jtsm_cal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_cal
// Calibration merge stage: tracks stick modes, updates the four biases from
// the lanes' scaled values and derives the drive and save flags.
// ----------------------------------------------------------------------------
module jtsm_cal
   import jtsm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      update,
   input  scaled_type [NUM_AXES-1:0] scaled,
   input  ctl_type                   ctl,
   output scaled_type [NUM_AXES-1:0] scaled_ff,
   output bias_type   [NUM_AXES-1:0] bias_ff,
   output flags_type                 flags_ff
);

   logic [1:0]                calibrating_ff;
   logic [1:0]                calibrating_in;
   logic [1:0]                sw;
   bias_type   [NUM_AXES-1:0] stored_ff;
   bias_type   [NUM_AXES-1:0] stored_in;
   flags_type                 flags_in;

   assign sw             = {ctl.left_cal_switch, ctl.right_cal_switch};
   assign calibrating_in = sw;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_bias
      logic               mode;
      logic               swi;
      logic signed [12:0] diff;

      assign mode = (i >= NUM_AXES / 2) ? calibrating_ff[1] : calibrating_ff[0];
      assign swi  = (i >= NUM_AXES / 2) ? sw[1] : sw[0];

      always_comb begin
         diff = {stored_ff[i][11], stored_ff[i]} - {2'b00, scaled[i]};
         priority if (swi && !mode) begin
            stored_in[i] = (scaled[i] > BIAS_LIMIT) ? bias_type'(BIAS_LIMIT)
                                                    : bias_type'(scaled[i]);
         end else if (!swi && mode) begin
            if (diff < -$signed({2'b00, BIAS_LIMIT})) begin
               stored_in[i] = -bias_type'(BIAS_LIMIT);
            end else if (diff > $signed({2'b00, BIAS_LIMIT})) begin
               stored_in[i] = bias_type'(BIAS_LIMIT);
            end else begin
               stored_in[i] = diff[11:0];
            end
         end else begin
            stored_in[i] = stored_ff[i];
         end
      end
   end

   always_comb begin
      flags_in.right_drive  = !calibrating_in[0];
      flags_in.left_drive   = !calibrating_in[1];
      flags_in.save_request = (calibrating_in == 2'b00) && !ctl.save_button;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrating_ff <= 2'b00;
         stored_ff      <= '0;
      end else if (update) begin
         calibrating_ff <= calibrating_in;
         stored_ff      <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         scaled_ff <= scaled;
         bias_ff   <= stored_in;
         flags_ff  <= flags_in;
      end
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_chk
      bias_range_a : assert property (@(posedge clock) disable iff (reset)
         (stored_ff[i] <= bias_type'(BIAS_LIMIT)) && (stored_ff[i] >= -bias_type'(BIAS_LIMIT)))
         else $error("stored bias out of range");
   end

endmodule

FILE: sv/jtsm_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsm_clamp
// One axis lane: adds the bias and clamps into the bias-dependent window.
// ----------------------------------------------------------------------------
module jtsm_clamp
   import jtsm_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  scaled_type  scaled,
   input  bias_type    bias,
   output logic [10:0] pulse_ff
);

   logic signed [12:0] sum;
   logic signed [12:0] twice;
   logic signed [12:0] lo;
   logic signed [12:0] hi;
   logic signed [12:0] value;

   always_comb begin
      sum   = $signed({2'b00, scaled}) + {bias[11], bias};
      twice = {bias, 1'b0};
      if (bias < 0) begin
         lo = $signed({2'b00, PULSE_MIN});
         hi = $signed({2'b00, PULSE_MAX}) + twice;
      end else begin
         lo = $signed({2'b00, PULSE_MIN}) + twice;
         hi = $signed({2'b00, PULSE_MAX});
      end
      priority if (sum < lo) begin
         value = lo;
      end else if (sum > hi) begin
         value = hi;
      end else begin
         value = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pulse_ff <= value[10:0];
      end
   end

endmodule

FILE: verif/tb_joystick_to_servo_calibrated_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_to_servo_calibrated_mapper_top
// Self-checking testbench for the calibrated joystick-to-servo mapper.
//
// Packets go in over the req_ channel, and a behavioral copy of the mapper
// (axis scaling, calibration capture and release, bias saturation, clamp
// window, drive and save flags) predicts each result. Results on the rsp_
// channel are checked field by field in order. Directed packets cover the
// axis extremes, every switch transition and the saturating bias cases.
// Random sessions with slowly toggling switches and fully random packets
// follow. The sender idles in bursts and the receiver stalls on patterns.
// ----------------------------------------------------------------------------
module tb_joystick_to_servo_calibrated_mapper_top;
   import jtsm_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   joystick_to_servo_calibrated_mapper_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // mapper state as predicted
   logic [1:0] cal_mode;
   int         axis_bias [NUM_AXES];

   rsp_payload_type pending_pulses [$];

   int error_count;
   int packets_sent;
   int results_checked;
   int cal_transitions;
   int save_requests;
   int burst_left;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_pulses.size());
         $display("FAIL joystick_to_servo_calibrated_mapper_top");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic int scaled_axis(logic [9:0] raw);
      return (int'(raw) * (int'(PULSE_MAX) - int'(PULSE_MIN))) / 1023 + int'(PULSE_MIN);
   endfunction

   function automatic int saturated_bias(int b);
      if (b > int'(BIAS_LIMIT))
         return int'(BIAS_LIMIT);
      if (b < -int'(BIAS_LIMIT))
         return -int'(BIAS_LIMIT);
      return b;
   endfunction

   function automatic logic [10:0] clamped_pulse(int s, int c);
      int v;
      int lo;
      int hi;
      v = s + c;
      if (c < 0) begin
         lo = int'(PULSE_MIN);
         hi = int'(PULSE_MAX) + 2 * c;
      end else begin
         lo = int'(PULSE_MIN) + 2 * c;
         hi = int'(PULSE_MAX);
      end
      if (v < lo)
         v = lo;
      if (v > hi)
         v = hi;
      return v[10:0];
   endfunction

   function automatic rsp_payload_type map_packet(req_payload_type p);
      int              s [NUM_AXES];
      logic [1:0]      stick_bit;
      logic            sw;
      int              first;
      rsp_payload_type r;
      s[0] = scaled_axis(p.right_x);
      s[1] = scaled_axis(p.right_y);
      s[2] = scaled_axis(p.left_x);
      s[3] = scaled_axis(p.left_y);
      for (int k = 0; k < 2; k++) begin
         stick_bit = (k == 0) ? MODE_RIGHT : MODE_LEFT;
         sw        = (k == 0) ? p.right_cal_switch : p.left_cal_switch;
         first     = 2 * k;
         if ((cal_mode & stick_bit) == 2'b00 && sw) begin
            cal_mode = cal_mode | stick_bit;
            for (int i = first; i < first + 2; i++)
               axis_bias[i] = saturated_bias(s[i]);
            cal_transitions++;
         end else if ((cal_mode & stick_bit) != 2'b00 && !sw) begin
            cal_mode = cal_mode & ~stick_bit;
            for (int i = first; i < first + 2; i++)
               axis_bias[i] = saturated_bias(axis_bias[i] - s[i]);
            cal_transitions++;
         end
      end
      r.right_x_pulse = clamped_pulse(s[0], axis_bias[0]);
      r.right_y_pulse = clamped_pulse(s[1], axis_bias[1]);
      r.left_x_pulse  = clamped_pulse(s[2], axis_bias[2]);
      r.left_y_pulse  = clamped_pulse(s[3], axis_bias[3]);
      r.right_drive   = ((cal_mode & MODE_RIGHT) == 2'b00);
      r.left_drive    = ((cal_mode & MODE_LEFT) == 2'b00);
      r.save_request  = (cal_mode == 2'b00) && !p.save_button;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------
   function automatic req_payload_type make_packet(int rx, int ry, int lx, int ly,
                                                   bit rsw, bit lsw, bit save_level);
      req_payload_type p;
      p.right_x          = rx[9:0];
      p.right_y          = ry[9:0];
      p.left_x           = lx[9:0];
      p.left_y           = ly[9:0];
      p.right_cal_switch = rsw;
      p.left_cal_switch  = lsw;
      p.save_button      = save_level;
      return p;
   endfunction

   function automatic int random_axis();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 1023;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   task automatic send_packet(input req_payload_type p);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      pending_pulses.push_back(map_packet(p));
      packets_sent++;
      do
         @(posedge clock);
      while (!req_ready);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_pulses.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // receiver and checker
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_pulses.size() == 0) begin
         $error("result with no transaction outstanding");
         error_count++;
         return;
      end
      want = pending_pulses.pop_front();
      check_field("right_x_pulse", want.right_x_pulse, got.right_x_pulse);
      check_field("right_y_pulse", want.right_y_pulse, got.right_y_pulse);
      check_field("left_x_pulse",  want.left_x_pulse,  got.left_x_pulse);
      check_field("left_y_pulse",  want.left_y_pulse,  got.left_y_pulse);
      check_field("right_drive",   want.right_drive,   got.right_drive);
      check_field("left_drive",    want.left_drive,    got.left_drive);
      check_field("save_request",  want.save_request,  got.save_request);
      if (want.save_request)
         save_requests++;
      results_checked++;
   endtask

   int rx_mode;
   int rx_tick;
   int rx_stall_left;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result(rsp_payload);
      rx_tick++;
      if (rx_tick % 97 == 0)
         rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (rx_tick % 5 < 2);
         default: begin
            if (rx_stall_left > 0) begin
               rx_stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_stall_left = $urandom_range(3, 12);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_axis_extremes();
      send_packet(make_packet(0, 0, 0, 0, 0, 0, 1));
      send_packet(make_packet(1023, 1023, 1023, 1023, 0, 0, 1));
      send_packet(make_packet(0, 1023, 512, 1, 0, 0, 0));
      send_packet(make_packet(1023, 0, 1, 512, 0, 0, 0));
      send_packet(make_packet(341, 682, 1022, 511, 0, 0, 1));
   endtask

   task automatic test_calibration_transitions();
      // right capture, hold, release into negative saturation
      send_packet(make_packet(0, 0, 700, 300, 1, 0, 0));
      send_packet(make_packet(1023, 0, 700, 300, 1, 0, 0));
      send_packet(make_packet(1023, 1023, 0, 1023, 0, 0, 1));
      send_packet(make_packet(0, 1023, 512, 0, 0, 0, 0));
      // capture saturating high, release to a small positive bias
      send_packet(make_packet(1023, 1023, 0, 0, 1, 0, 1));
      send_packet(make_packet(0, 0, 0, 0, 0, 0, 1));
      send_packet(make_packet(512, 100, 900, 40, 0, 0, 1));
      // left alone, then both at once, releases with save pressed
      send_packet(make_packet(200, 200, 100, 100, 0, 1, 0));
      send_packet(make_packet(200, 200, 100, 100, 0, 0, 0));
      send_packet(make_packet(50, 950, 300, 800, 1, 1, 0));
      send_packet(make_packet(1023, 0, 1023, 0, 1, 1, 0));
      send_packet(make_packet(1023, 0, 0, 1023, 1, 0, 0));
      send_packet(make_packet(0, 1023, 0, 1023, 0, 0, 0));
      send_packet(make_packet(777, 222, 333, 888, 0, 0, 0));
   endtask

   task automatic test_random_sessions(input int count);
      bit rsw;
      bit lsw;
      rsw = 1'b0;
      lsw = 1'b0;
      repeat (count) begin
         if ($urandom_range(0, 11) == 0)
            rsw = ~rsw;
         if ($urandom_range(0, 11) == 0)
            lsw = ~lsw;
         send_packet(make_packet(random_axis(), random_axis(), random_axis(), random_axis(),
                                 rsw, lsw, $urandom_range(0, 1)));
      end
   endtask

   task automatic test_pause_until_empty();
      test_random_sessions(20);
      wait_drained();
      test_random_sessions(20);
   endtask

   task automatic test_random_noise(input int count);
      logic [63:0]     noise;
      req_payload_type p;
      repeat (count) begin
         noise = {$urandom, $urandom};
         p     = noise[$bits(req_payload_type)-1:0];
         send_packet(p);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_ready   <= 1'b0;
      cal_mode        = 2'b00;
      axis_bias       = '{default: 0};
      error_count     = 0;
      packets_sent    = 0;
      results_checked = 0;
      cal_transitions = 0;
      save_requests   = 0;
      burst_left      = 0;
      cycle_count     = 0;
      rx_mode         = 0;
      rx_tick         = 0;
      rx_stall_left   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_axis_extremes();
      test_calibration_transitions();
      test_random_sessions(700);
      test_pause_until_empty();
      test_random_noise(400);

      wait_drained();
      repeat (10) @(posedge clock);

      $display("%0d packets sent, %0d results checked", packets_sent, results_checked);
      $display("%0d calibration mode changes, %0d save requests seen",
               cal_transitions, save_requests);
      if (error_count == 0 && pending_pulses.size() == 0) begin
         $display("PASS joystick_to_servo_calibrated_mapper_top");
      end else begin
         $display("FAIL joystick_to_servo_calibrated_mapper_top");
      end
      $finish;
   end

endmodule
